@@ src/ctfp_pkg.sv @@
// Package for the cron time field parser: parse phases, controller/datapath
// command and status structs, character classes and name matching.
// No dependencies.
`timescale 1ns / 1ps
package ctfp_pkg;

  typedef enum logic [3:0] {
    PH_FIRST  = 4'd0,
    PH_ITEM   = 4'd1,
    PH_NUM1   = 4'd2,
    PH_STAR   = 4'd3,
    PH_DASH   = 4'd4,
    PH_NUM2   = 4'd5,
    PH_SLASH  = 4'd6,
    PH_STEP   = 4'd7,
    PH_SKIPNB = 4'd8,
    PH_SKIPB  = 4'd9,
    PH_EXPAND = 4'd10,
    PH_OUT    = 4'd11
  } phase_t;

  localparam logic [1:0] CFG_LOW  = 2'd0;
  localparam logic [1:0] CFG_HIGH = 2'd1;
  localparam logic [1:0] CFG_NAME = 2'd2;

  localparam logic [1:0] NAMES_MONTH = 2'd1;
  localparam logic [1:0] NAMES_WDAY  = 2'd2;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;

  // what the controller asks of the datapath on one accepted character
  typedef struct packed {
    logic tok_clear;   // clear token before adding
    logic tok_add;     // append character
    logic set_star;    // range = low..high
    logic lat_start;   // range_start = token value
    logic end_high;    // range_end = field_high
    logic lat_end;     // range_end = token value
    logic lat_step;    // step = token value
    logic step_one;    // step = 1
    logic exp_start;   // begin range walk at range_start
    logic exp_next;    // walk one value
    logic set_single;  // set bit of token value
    logic clear_all;   // field reset
    logic first_char;  // record star flag
  } cmd_t;

  typedef struct packed {
    logic tok_ok;      // token value valid (names allowed)
    logic tok_ok_nn;   // token value valid (no names)
    logic tok_zero;    // token value is zero
    logic tok_full;    // appending would reach the token limit
    logic val_legal;   // token value within low..high
    logic exp_done;    // walk past range end
    logic exp_bad;     // current walk value illegal
  } stat_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  // returns {hit, index}
  function automatic logic [4:0] month_idx(input logic [23:0] t);
    case (t)
      "jan": return 5'h10; "feb": return 5'h11; "mar": return 5'h12;
      "apr": return 5'h13; "may": return 5'h14; "jun": return 5'h15;
      "jul": return 5'h16; "aug": return 5'h17; "sep": return 5'h18;
      "oct": return 5'h19; "nov": return 5'h1A; "dec": return 5'h1B;
      default: return 5'h00;
    endcase
  endfunction

  function automatic logic [4:0] wday_idx(input logic [23:0] t);
    case (t)
      "sun": return 5'h10; "mon": return 5'h11; "tue": return 5'h12;
      "wed": return 5'h13; "thu": return 5'h14; "fri": return 5'h15;
      "sat": return 5'h16;
      default: return 5'h00;
    endcase
  endfunction

endpackage

@@ src/cron_time_field_parser.sv @@
// Cron time field parser, one character per transfer.
// A result is registered when its closing character is taken, or at the end
// of the range walk, which marks each stepped value in turn. Throughput: one
// character per cycle outside range walks and the result phase, which holds
// input until out_tready takes the result. Reset (rst_n low, synchronous)
// resets phase, config and datapath registers and clears all field state.
`timescale 1ns / 1ps
module cron_time_field_parser #(
  parameter int MASK_BITS       = 60,
  parameter int MAX_TOKEN_CHARS = 100
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // in_char
  input  logic        in_tlast,   // at_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // field_mask[59:0], next_char, zero fill
  output logic [2:0]  out_tuser,  // parse_error, next_is_end, began_with_star
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_wdata
);
  logic       low_r;
  logic [5:0] high_r;
  logic [1:0] names_r;
  logic       in_fire, res_load, res_err, res_end, star;
  logic [7:0] res_char;
  logic [MASK_BITS-1:0] mask;
  logic [59:0] omask;
  logic        ostar_r;
  ctfp_pkg::cmd_t  cmd;
  ctfp_pkg::stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r <= 1'b0; high_r <= 6'd59; names_r <= 2'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        ctfp_pkg::CFG_LOW:  low_r <= cfg_wdata[0];
        ctfp_pkg::CFG_HIGH: high_r <= cfg_wdata;
        ctfp_pkg::CFG_NAME: names_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  assign in_fire = in_tvalid && in_tready;

  ctfp_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .ch(in_tdata), .at_end(in_tlast), .stat, .out_tready,
    .in_ready(in_tready), .out_valid(out_tvalid), .res_err, .res_char, .res_end,
    .res_load, .cmd
  );

  ctfp_datapath #(.MASK_BITS(MASK_BITS), .MAX_TOKEN_CHARS(MAX_TOKEN_CHARS)) u_dp (
    .clk, .rst_n, .ch(in_tdata), .field_low(low_r), .field_high(high_r),
    .name_set(names_r), .cmd, .stat, .mask, .star
  );

  // mask holds its final value until the result transfer clears it
  assign omask = res_err ? 60'd0 : 60'(mask);

  always_ff @(posedge clk) begin
    if (res_load) begin
      ostar_r <= cmd.first_char ? (in_tdata == ctfp_pkg::CH_STAR) : star;
    end
  end

  assign out_tdata = {4'd0, res_char, omask};
  assign out_tuser = {ostar_r, res_end, res_err};
endmodule

@@ src/ctfp_datapath.sv @@
// Datapath of the cron time field parser: token buffer, number, range
// registers, range walker and mask. Depends on ctfp_pkg.
`timescale 1ns / 1ps
module ctfp_datapath #(
  parameter int MASK_BITS       = 60,
  parameter int MAX_TOKEN_CHARS = 100
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           ch,
  input  logic                 field_low,
  input  logic [5:0]           field_high,
  input  logic [1:0]           name_set,
  input  ctfp_pkg::cmd_t       cmd,
  output ctfp_pkg::stat_t      stat,
  output logic [MASK_BITS-1:0] mask,
  output logic                 star
);
  localparam int LW = $clog2(MAX_TOKEN_CHARS + 1);

  logic [23:0]          tok_r, tok_nxt;
  logic [LW-1:0]        len_r, len_nxt;
  logic                 digits_r, digits_nxt;
  logic [7:0]           num_r, num_nxt;
  logic [7:0]           rs_r, rs_nxt, re_r, re_nxt, st_r, st_nxt;
  logic [8:0]           cur_r, cur_nxt;
  logic [MASK_BITS-1:0] mask_r, mask_nxt;
  logic                 star_r, star_nxt;

  logic [4:0]  nm;
  logic [7:0]  tval;
  logic        named;
  logic [11:0] prod;
  logic [7:0]  base_num;
  logic [7:0]  wv;
  logic [LW-1:0] base_len;
  logic [23:0] base_tok;
  logic        base_dig;

  always_comb begin
    nm = (name_set == ctfp_pkg::NAMES_MONTH) ? ctfp_pkg::month_idx(tok_r)
       : (name_set == ctfp_pkg::NAMES_WDAY) ? ctfp_pkg::wday_idx(tok_r) : 5'd0;
    named = nm[4] && (len_r == LW'(3));
    tval  = named ? 8'({4'd0, nm[3:0]}) + 8'(field_low) : num_r;
    stat.tok_ok    = (len_r != '0) && (named || digits_r);
    stat.tok_ok_nn = (len_r != '0) && digits_r;
    stat.tok_zero  = num_r == 8'd0;
    stat.tok_full  = (cmd.tok_clear ? 32'd1 : 32'(len_r) + 32'd1) >= 32'(MAX_TOKEN_CHARS);
    stat.val_legal = tval >= 8'(field_low) && tval <= 8'(field_high);
    stat.exp_done  = cur_r > 9'(re_r);
    wv             = cur_r[7:0];
    stat.exp_bad   = cur_r[7:0] < 8'(field_low) || cur_r[7:0] > 8'(field_high);
  end

  always_comb begin
    base_tok = cmd.tok_clear ? 24'd0 : tok_r;
    base_len = cmd.tok_clear ? '0 : len_r;
    base_dig = cmd.tok_clear ? 1'b1 : digits_r;
    base_num = cmd.tok_clear ? 8'd0 : num_r;
    tok_nxt = base_tok; len_nxt = base_len; digits_nxt = base_dig; num_nxt = base_num;
    prod = 12'(base_num) * 12'd10 + 12'(ch - 8'h30);
    if (cmd.tok_add) begin
      if (base_len == '0) tok_nxt[23:16] = ctfp_pkg::to_lower(ch);
      else if (base_len == LW'(1)) tok_nxt[15:8] = ctfp_pkg::to_lower(ch);
      else if (base_len == LW'(2)) tok_nxt[7:0] = ctfp_pkg::to_lower(ch);
      len_nxt = base_len + LW'(1);
      if (ctfp_pkg::is_digit(ch)) num_nxt = (prod > 12'd255) ? 8'd255 : prod[7:0];
      else digits_nxt = 1'b0;
    end
    rs_nxt = rs_r; re_nxt = re_r; st_nxt = st_r; cur_nxt = cur_r;
    mask_nxt = mask_r; star_nxt = star_r;
    if (cmd.set_star) begin rs_nxt = 8'(field_low); re_nxt = 8'(field_high); end
    if (cmd.lat_start) rs_nxt = tval;
    if (cmd.end_high) re_nxt = 8'(field_high);
    if (cmd.lat_end) re_nxt = tval;
    if (cmd.step_one) st_nxt = 8'd1;
    if (cmd.lat_step) st_nxt = num_r;
    if (cmd.exp_start) cur_nxt = 9'(rs_r);
    if (cmd.exp_next) begin
      if (9'(wv - 8'(field_low)) < 9'(MASK_BITS))
        mask_nxt[($clog2(MASK_BITS))'(wv - 8'(field_low))] = 1'b1;
      cur_nxt = cur_r + 9'(st_r);
    end
    if (cmd.set_single && 9'(tval - 8'(field_low)) < 9'(MASK_BITS))
      mask_nxt[($clog2(MASK_BITS))'(tval - 8'(field_low))] = 1'b1;
    if (cmd.first_char) star_nxt = ch == ctfp_pkg::CH_STAR;
    if (cmd.clear_all) begin
      tok_nxt = 24'd0; len_nxt = '0; digits_nxt = 1'b1; num_nxt = 8'd0;
      rs_nxt = 8'd0; re_nxt = 8'd0; st_nxt = 8'd1; mask_nxt = '0; star_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 24'd0; len_r <= '0; digits_r <= 1'b1; num_r <= 8'd0;
      rs_r <= 8'd0; re_r <= 8'd0; st_r <= 8'd1; mask_r <= '0; star_r <= 1'b0;
      cur_r <= 9'd0;
    end else begin
      tok_r <= tok_nxt; len_r <= len_nxt; digits_r <= digits_nxt; num_r <= num_nxt;
      rs_r <= rs_nxt; re_r <= re_nxt; st_r <= st_nxt; mask_r <= mask_nxt;
      star_r <= star_nxt; cur_r <= cur_nxt;
    end
  end

  assign mask = mask_r;
  assign star = star_r;
endmodule

@@ src/ctfp_ctrl.sv @@
// Controller of the cron time field parser: parse phase machine, range walk
// sequencing and result register. Depends on ctfp_pkg.
`timescale 1ns / 1ps
module ctfp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_fire,
  input  logic [7:0]      ch,
  input  logic            at_end,
  input  ctfp_pkg::stat_t stat,
  input  logic            out_tready,
  output logic            in_ready,
  output logic            out_valid,
  output logic            res_err,
  output logic [7:0]      res_char,
  output logic            res_end,
  output logic            res_load,
  output ctfp_pkg::cmd_t  cmd
);
  ctfp_pkg::phase_t ph_r, ph_nxt;
  logic [7:0] pch_r, pch_nxt;   // character that ended the range
  logic ov_r, ov_nxt;
  logic err_r, err_nxt, end_r, end_nxt;
  logic [7:0] rc_r, rc_nxt;

  logic done, fail;
  ctfp_pkg::phase_t eph;
  logic [3:0] tail_ph;
  logic [7:0] c;

  // list continuation after an item, for character x
  function automatic logic [4:0] lnext(input logic [7:0] x);
    // {done, phase}
    if (x == ctfp_pkg::CH_COMMA) return {1'b0, ctfp_pkg::PH_ITEM};
    if (ctfp_pkg::is_blank(x)) return {1'b0, ctfp_pkg::PH_SKIPB};
    if (x == ctfp_pkg::CH_NL) return {1'b1, ctfp_pkg::PH_FIRST};
    return {1'b0, ctfp_pkg::PH_SKIPNB};
  endfunction

  assign in_ready = (ph_r != ctfp_pkg::PH_EXPAND) && (ph_r != ctfp_pkg::PH_OUT);
  assign out_valid = ov_r;
  assign res_err = err_r;
  assign res_char = rc_r;
  assign res_end = end_r;
  assign c = in_fire ? ch : pch_r;

  always_comb begin
    ph_nxt = ph_r; pch_nxt = pch_r;
    done = 1'b0; fail = 1'b0;
    eph = (ph_r == ctfp_pkg::PH_FIRST) ? ctfp_pkg::PH_ITEM : ph_r;
    tail_ph = ctfp_pkg::PH_FIRST;
    if (ph_r == ctfp_pkg::PH_EXPAND) begin
      if (stat.exp_done) begin
        {done, tail_ph} = lnext(pch_r);
        ph_nxt = ctfp_pkg::phase_t'(tail_ph);
      end else if (stat.exp_bad) fail = 1'b1;
    end else if (ph_r == ctfp_pkg::PH_OUT) begin
      if (!ov_r || out_tready) ph_nxt = ctfp_pkg::PH_FIRST;
    end else if (in_fire) begin
      if (at_end) fail = 1'b1;
      else begin
        case (eph)
          ctfp_pkg::PH_ITEM:
            if (ch == ctfp_pkg::CH_STAR) ph_nxt = ctfp_pkg::PH_STAR;
            else if (!ctfp_pkg::is_alnum(ch) || stat.tok_full) fail = 1'b1;
            else ph_nxt = ctfp_pkg::PH_NUM1;
          ctfp_pkg::PH_DASH, ctfp_pkg::PH_SLASH:
            if (!ctfp_pkg::is_alnum(ch) || stat.tok_full) fail = 1'b1;
            else ph_nxt = (eph == ctfp_pkg::PH_DASH) ? ctfp_pkg::PH_NUM2 : ctfp_pkg::PH_STEP;
          ctfp_pkg::PH_STAR:
            if (ch == ctfp_pkg::CH_SLASH) ph_nxt = ctfp_pkg::PH_SLASH;
            else begin ph_nxt = ctfp_pkg::PH_EXPAND; pch_nxt = ch; end
          ctfp_pkg::PH_NUM1:
            if (ctfp_pkg::is_alnum(ch)) fail = stat.tok_full;
            else if (!stat.tok_ok) fail = 1'b1;
            else if (ch == ctfp_pkg::CH_SLASH) ph_nxt = ctfp_pkg::PH_SLASH;
            else if (ch == ctfp_pkg::CH_DASH) ph_nxt = ctfp_pkg::PH_DASH;
            else if (!stat.val_legal) fail = 1'b1;
            else begin {done, tail_ph} = lnext(ch); ph_nxt = ctfp_pkg::phase_t'(tail_ph); end
          ctfp_pkg::PH_NUM2:
            if (ctfp_pkg::is_alnum(ch)) fail = stat.tok_full;
            else if (!stat.tok_ok) fail = 1'b1;
            else if (ch == ctfp_pkg::CH_SLASH) ph_nxt = ctfp_pkg::PH_SLASH;
            else begin ph_nxt = ctfp_pkg::PH_EXPAND; pch_nxt = ch; end
          ctfp_pkg::PH_STEP:
            if (ctfp_pkg::is_alnum(ch)) fail = stat.tok_full;
            else if (!stat.tok_ok_nn || stat.tok_zero) fail = 1'b1;
            else begin ph_nxt = ctfp_pkg::PH_EXPAND; pch_nxt = ch; end
          ctfp_pkg::PH_SKIPNB:
            if (ctfp_pkg::is_blank(ch)) ph_nxt = ctfp_pkg::PH_SKIPB;
            else done = ch == ctfp_pkg::CH_NL;
          ctfp_pkg::PH_SKIPB:
            done = !ctfp_pkg::is_blank(ch);
          default: fail = 1'b1;
        endcase
      end
    end
    if (done || fail) ph_nxt = ctfp_pkg::PH_OUT;
  end

  always_comb begin
    cmd = '0;
    res_load = done || fail;
    cmd.first_char = in_fire && ph_r == ctfp_pkg::PH_FIRST && !at_end;
    if (in_fire && !at_end) begin
      case (eph)
        ctfp_pkg::PH_ITEM:
          if (ch == ctfp_pkg::CH_STAR) cmd.set_star = 1'b1;
          else begin cmd.tok_clear = 1'b1; cmd.tok_add = ctfp_pkg::is_alnum(ch); end
        ctfp_pkg::PH_DASH, ctfp_pkg::PH_SLASH: begin
          cmd.tok_clear = 1'b1; cmd.tok_add = ctfp_pkg::is_alnum(ch);
        end
        ctfp_pkg::PH_STAR: begin
          cmd.step_one = ch != ctfp_pkg::CH_SLASH;
          cmd.exp_start = ch != ctfp_pkg::CH_SLASH;
        end
        ctfp_pkg::PH_NUM1:
          if (ctfp_pkg::is_alnum(ch)) cmd.tok_add = 1'b1;
          else if (stat.tok_ok) begin
            cmd.lat_start = 1'b1;
            cmd.end_high = ch == ctfp_pkg::CH_SLASH;
            cmd.set_single = ch != ctfp_pkg::CH_SLASH && ch != ctfp_pkg::CH_DASH;
          end
        ctfp_pkg::PH_NUM2:
          if (ctfp_pkg::is_alnum(ch)) cmd.tok_add = 1'b1;
          else if (stat.tok_ok) begin
            cmd.lat_end = 1'b1;
            cmd.step_one = ch != ctfp_pkg::CH_SLASH;
            cmd.exp_start = ch != ctfp_pkg::CH_SLASH;
          end
        ctfp_pkg::PH_STEP:
          if (ctfp_pkg::is_alnum(ch)) cmd.tok_add = 1'b1;
          else begin cmd.lat_step = 1'b1; cmd.exp_start = 1'b1; end
        default: ;
      endcase
    end
    if (ph_r == ctfp_pkg::PH_EXPAND && !stat.exp_done && !stat.exp_bad) cmd.exp_next = 1'b1;
    cmd.clear_all = ph_r == ctfp_pkg::PH_OUT && (!ov_r || out_tready);
  end

  always_comb begin
    ov_nxt = ov_r && !out_tready;
    err_nxt = err_r; rc_nxt = rc_r; end_nxt = end_r;
    if (res_load) begin
      ov_nxt = 1'b1; err_nxt = fail;
      rc_nxt = fail ? 8'd0 : c;
      end_nxt = fail && in_fire && at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= ctfp_pkg::PH_FIRST; ov_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt; ov_r <= ov_nxt;
    end
    pch_r <= pch_nxt; err_r <= err_nxt; rc_r <= rc_nxt; end_r <= end_nxt;
  end
endmodule

@@ src/ctfp_checker.sv @@
// Port-level checks for the cron time field parser; bound to the top level.
// Depends on nothing but the top level's ports.
`timescale 1ns / 1ps
module ctfp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic [2:0]  out_tuser
);
  a_err_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[67:0] == 68'd0) else $error("mask on error");
  a_end_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0]) else $error("end without error");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("dropped");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !in_tready) else $error("ready with new result");
endmodule

bind cron_time_field_parser ctfp_checker u_chk (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready, .out_tdata, .out_tuser
);
